/* sv/interleaved_dual_crc16_string_id_macros.svh */
// Assertion macros for the interleaved dual CRC-16 string id block.
// Depends on nothing; included by the top level only.
`ifndef INTERLEAVED_DUAL_CRC16_STRING_ID_MACROS_SVH
`define INTERLEAVED_DUAL_CRC16_STRING_ID_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ICDS_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ICDS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/icds_pkg.sv */
// Package for the interleaved dual CRC-16 string id block.
// Holds the CRC constants, the case fold and the byte-wide CRC step; no dependencies.
package icds_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned CRC_W  = 16;
    localparam int unsigned ID_W   = 2 * CRC_W;

    localparam logic [CRC_W-1:0]  CRC_SEED   = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY   = 16'h1021;
    localparam logic [CHAR_W-1:0] UPPER_A    = 8'd65;
    localparam logic [CHAR_W-1:0] UPPER_Z    = 8'd90;
    localparam logic [CHAR_W-1:0] FOLD_DELTA = 8'd32;
    localparam logic [CHAR_W-1:0] END_CHAR   = 8'd0;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [CRC_W-1:0]  t_crc;
    typedef logic [ID_W-1:0]   t_id;

    // Fold ASCII upper case letters to lower case; all other bytes pass.
    function automatic t_char fold_byte(input t_char b);
        t_char r;
        r = b;
        if ((b >= UPPER_A) && (b <= UPPER_Z)) begin
            r = b + FOLD_DELTA;
        end
        return r;
    endfunction

    // One byte of MSB-first CRC-16, polynomial 0x1021, eight shift steps.
    function automatic t_crc crc_update(input t_crc crc, input t_char b);
        t_crc r;
        r = crc ^ {b, {(CRC_W-CHAR_W){1'b0}}};
        for (int i = 0; i < CHAR_W; i++) begin
            if (r[CRC_W-1]) begin
                r = {r[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[CRC_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

/* sv/icds_if.sv */
// Valid/ready channel interfaces for the string id block: byte in, id out.
// Depends on icds_pkg for the payload types.
interface icds_char_if import icds_pkg::*; ();
    logic  valid;
    logic  ready;
    t_char char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface icds_id_if import icds_pkg::*; ();
    logic valid;
    logic ready;
    t_id  string_id;

    modport source (output valid, output string_id, input ready);
    modport sink   (input valid, input string_id, output ready);
endinterface

/* sv/interleaved_dual_crc16_string_id.sv */
// A terminating zero byte's id passes the input register, then the output register.
// Throughput: one byte per cycle; the only stall is a zero byte meeting a full output
// register, whose id has not been taken yet.
// The CRC step for a byte is an eight-step shift chain between the input and state registers.
// Reset (synchronous, active low) empties both registers and sets both CRCs to 0xFFFF,
// with the next byte at an even position.
`include "interleaved_dual_crc16_string_id_macros.svh"

module interleaved_dual_crc16_string_id import icds_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    icds_char_if.sink    i_char,
    icds_id_if.source    o_id
);

    logic  r_in_valid;
    t_char r_in_char;
    logic  r_out_valid;
    t_id   r_out_id;
    t_crc  r_even_crc;
    t_crc  r_odd_crc;
    logic  r_pos_odd;

    logic  in_zero;
    logic  out_free;
    logic  stage_go;
    t_char folded;
    t_crc  sel_crc;
    t_crc  next_crc;

    // The stage only waits when it must hand an id to a full output register.
    assign in_zero  = (r_in_char == END_CHAR);
    assign out_free = !r_out_valid || o_id.ready;
    assign stage_go = r_in_valid && (!in_zero || out_free);

    assign i_char.ready = !r_in_valid || stage_go;
    assign o_id.valid     = r_out_valid;
    assign o_id.string_id = r_out_id;

    // Fold and run the CRC of whichever register this byte's parity selects.
    assign folded   = fold_byte(r_in_char);
    assign sel_crc  = r_pos_odd ? r_odd_crc : r_even_crc;
    assign next_crc = crc_update(sel_crc, folded);

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_char <= i_char.char_code;
        end
    end

    // CRC state: update on a data byte, reseed after the end of a string.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_even_crc <= CRC_SEED;
            r_odd_crc  <= CRC_SEED;
            r_pos_odd  <= 1'b0;
        end else if (stage_go) begin
            if (in_zero) begin
                r_even_crc <= CRC_SEED;
                r_odd_crc  <= CRC_SEED;
                r_pos_odd  <= 1'b0;
            end else begin
                if (r_pos_odd) begin
                    r_odd_crc <= next_crc;
                end else begin
                    r_even_crc <= next_crc;
                end
                r_pos_odd <= !r_pos_odd;
            end
        end
    end

    // Output register holds the id until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_go && in_zero) begin
            r_out_valid <= 1'b1;
        end else if (o_id.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_go && in_zero) begin
            r_out_id <= {r_even_crc, r_odd_crc};
        end
    end

    // Checks on the id path and the state handling.
    `ICDS_ASSERT_NEXT(a_id_loaded, i_clk, i_rst_n, stage_go && in_zero, r_out_valid && (r_out_id == $past({r_even_crc, r_odd_crc})), "id not loaded from CRC state")
    `ICDS_ASSERT_NEXT(a_reseed, i_clk, i_rst_n, stage_go && in_zero, (r_even_crc == CRC_SEED) && (r_odd_crc == CRC_SEED) && !r_pos_odd, "state not reseeded after end of string")
    `ICDS_ASSERT_NEXT(a_parity_toggle, i_clk, i_rst_n, stage_go && !in_zero, r_pos_odd != $past(r_pos_odd), "position parity did not toggle")
    `ICDS_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !o_id.ready, !(stage_go && in_zero), "pending id overwritten")

endmodule

/* sim/interleaved_dual_crc16_string_id_checker.sv */
// Checker for the interleaved dual CRC-16 string id block: watches both channels,
// predicts every id from the accepted bytes and compares it with the id that comes out.
// Depends on icds_pkg for the payload types and the CRC constants.
module interleaved_dual_crc16_string_id_checker import icds_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_char_valid,
    input  logic        i_char_ready,
    input  t_char       i_char_code,
    input  logic        i_id_valid,
    input  logic        i_id_ready,
    input  t_id         i_string_id,
    output int unsigned o_error_count,
    output int unsigned o_ids_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SHOWN_ERRORS = 10;

    // Running sums for the string in progress and the ids still owed by the block.
    t_crc        even_sum;
    t_crc        odd_sum;
    logic        odd_slot;
    t_id         owed_ids[$];
    int unsigned mismatches;

    // ASCII capitals go to lower case; any other byte is left as it is.
    function automatic t_char lower_case(input t_char c);
        t_char folded;
        folded = c;
        if ((c >= UPPER_A) && (c <= UPPER_Z)) begin
            folded = c | 8'h20;
        end
        return folded;
    endfunction

    // MSB-first CRC over one byte, one message bit at a time.
    function automatic t_crc crc16_absorb(input t_crc crc, input t_char c);
        t_crc sum;
        logic feedback;
        sum = crc;
        for (int k = CHAR_W - 1; k >= 0; k--) begin
            feedback = sum[CRC_W-1] ^ c[k];
            sum      = sum << 1;
            if (feedback) begin
                sum = sum ^ CRC_POLY;
            end
        end
        return sum;
    endfunction

    // Count a mismatch and show the first few of them.
    function automatic void note_error(input t_id want, input t_id got, input logic orphan);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS) begin
            if (orphan) begin
                $display("%0t: id %08h arrived with none expected", $time, got);
            end else begin
                $display("%0t: string id mismatch: expected %08h, got %08h", $time, want, got);
            end
        end
    endfunction

    // Follow every beat on both channels.
    always @(posedge i_clk) begin : watch
        t_id want;
        if (!i_rst_n) begin
            even_sum = CRC_SEED;
            odd_sum  = CRC_SEED;
            odd_slot = 1'b0;
        end else begin
            // A byte beat either ends the string or feeds the CRC of its parity.
            if (i_char_valid && i_char_ready) begin
                if (i_char_code == END_CHAR) begin
                    owed_ids.push_back({even_sum, odd_sum});
                    even_sum = CRC_SEED;
                    odd_sum  = CRC_SEED;
                    odd_slot = 1'b0;
                end else begin
                    if (odd_slot) begin
                        odd_sum = crc16_absorb(odd_sum, lower_case(i_char_code));
                    end else begin
                        even_sum = crc16_absorb(even_sum, lower_case(i_char_code));
                    end
                    odd_slot = ~odd_slot;
                end
            end
            // An id beat is matched against the oldest owed id.
            if (i_id_valid && i_id_ready) begin
                if (owed_ids.size() == 0) begin
                    note_error('0, i_string_id, 1'b1);
                end else begin
                    want = owed_ids.pop_front();
                    if (i_string_id !== want) begin
                        note_error(want, i_string_id, 1'b0);
                    end
                end
            end
        end
        o_error_count <= mismatches;
        o_ids_owed    <= owed_ids.size();
    end

endmodule

/* sim/interleaved_dual_crc16_string_id_test.sv */
// Top of the string id testbench: clock, reset, byte and id traffic with random idling,
// watchdog and verdict. Depends on icds_pkg, icds_if, the block and its checker.
module interleaved_dual_crc16_string_id_test import icds_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_BYTES = 450;
    localparam int unsigned MAX_WAIT     = 13;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned QUIET_LIMIT  = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int unsigned error_count;
    int unsigned ids_owed;
    int unsigned bytes_sent;
    int unsigned quiet_cycles;
    bit          calm;
    t_char       line_buf[$];

    icds_char_if char_if ();
    icds_id_if   id_if ();

    interleaved_dual_crc16_string_id u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_if),
        .o_id    (id_if)
    );

    interleaved_dual_crc16_string_id_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_char_valid  (char_if.valid),
        .i_char_ready  (char_if.ready),
        .i_char_code   (char_if.char_code),
        .i_id_valid    (id_if.valid),
        .i_id_ready    (id_if.ready),
        .i_string_id   (id_if.string_id),
        .o_error_count (error_count),
        .o_ids_owed    (ids_owed)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Send the bytes in line_buf and then the terminating zero, one beat each,
    // with a random gap in front of every beat unless the run is in a calm stretch.
    task automatic send_line();
        int unsigned gap;
        t_char       c;
        line_buf.push_back(END_CHAR);
        while (line_buf.size() != 0) begin
            c   = line_buf.pop_front();
            gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (gap != 0) begin
                char_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            char_if.valid     <= 1'b1;
            char_if.char_code <= c;
            @(posedge i_clk);
            while (!char_if.ready) @(posedge i_clk);
            bytes_sent++;
        end
    endtask

    // One random nonzero byte, weighted toward letters of both cases.
    function automatic t_char random_char();
        t_char c;
        case ($urandom_range(0, 3))
            0: c = t_char'($urandom_range(UPPER_A, UPPER_Z));
            1: c = t_char'($urandom_range(UPPER_A + FOLD_DELTA, UPPER_Z + FOLD_DELTA));
            default: c = t_char'($urandom_range(1, 255));
        endcase
        return c;
    endfunction

    // Stimulus: directed strings, then random strings, then drain and verdict.
    initial begin
        int unsigned len;
        char_if.valid     <= 1'b0;
        char_if.char_code <= END_CHAR;
        i_rst_n           <= 1'b0;
        bytes_sent = 0;
        calm       = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty string, a lone capital, then the edges of the fold range.
        send_line();
        line_buf = {UPPER_A};
        send_line();
        line_buf = {8'd64, UPPER_A, UPPER_Z, 8'd91, 8'd96, 8'd97, 8'd122, 8'd123};
        send_line();
        // High bytes pass unfolded; odd length leaves the odd CRC one byte behind.
        calm     = 1'b1;
        line_buf = {8'hFF, 8'h80, 8'h7F, 8'h01, 8'hAA};
        send_line();
        calm = 1'b0;
        send_line();

        // Random strings, mostly short, now and then long.
        while (bytes_sent < RANDOM_BYTES) begin
            calm = ($urandom_range(0, 4) == 0);
            len  = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(0, 10);
            repeat (len) line_buf.push_back(random_char());
            send_line();
        end
        char_if.valid <= 1'b0;

        // Wait for the owed ids, then wait out the drain period for anything stray.
        do @(posedge i_clk); while (ids_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** interleaved_dual_crc16_string_id: PASSED **");
        end else begin
            $display("** interleaved_dual_crc16_string_id: FAILED **");
        end
        $finish;
    end

    // Id sink: a random stall before each beat, none in a calm stretch.
    initial begin
        int unsigned stall;
        id_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall != 0) begin
                id_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            id_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!id_if.valid) @(posedge i_clk);
        end
    end

    // Watchdog: too many cycles in a row without a beat on either channel.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((char_if.valid && char_if.ready) || (id_if.valid && id_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("** interleaved_dual_crc16_string_id: FAILED **");
        $finish;
    end

endmodule
